// ===== rtl/wmms_pkg.sv =====
// ----------------------------------------------------------------------------
// wmms_pkg
// Shared types and constants for the wall motor move sequencer.
// ----------------------------------------------------------------------------
package wmms_pkg;

  localparam int unsigned TickW      = 10;
  localparam int unsigned InDataW    = 8;
  localparam int unsigned OutDataW   = 8;

  localparam logic [TickW-1:0] TimeoutReset = TickW'(500);
  localparam logic [TickW-1:0] WaitMax      = {TickW{1'b1}};

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_START   = 3'd2,
    PH_WAIT    = 3'd3,
    PH_DONE    = 3'd4,
    PH_TIMEOUT = 3'd5,
    PH_FAULT   = 3'd6,
    PH_BLOCKED = 3'd7
  } phase_t;

  typedef enum logic [1:0] {
    RPT_DONE    = 2'd0,
    RPT_TIMEOUT = 2'd1,
    RPT_FAULT   = 2'd2,
    RPT_BLOCKED = 2'd3
  } report_t;

  typedef struct packed {
    logic move_request;
    logic move_target;
    logic driver_released;
    logic driver_ok;
    logic endpoint_on_hit;
    logic endpoint_off_hit;
  } tick_in_t;

  typedef struct packed {
    logic    motor_direction;
    logic    motor_run;
    logic    report_valid;
    report_t report_code;
    logic    busy_res;
  } tick_out_t;

endpackage

// ===== rtl/wmms_core.sv =====
// ----------------------------------------------------------------------------
// wmms_core
// Move sequencer state and its per-tick update; one tick per accepted beat.
// ----------------------------------------------------------------------------
module wmms_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [wmms_pkg::TickW-1:0]     cfg_wr_data,
  input  logic                           tick_en,
  input  wmms_pkg::tick_in_t             tick_in,
  output wmms_pkg::tick_out_t            tick_out
);
  import wmms_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [TickW-1:0]  wait_r, wait_nxt;
  logic [TickW-1:0]  timeout_r;
  logic              pending_r, pending_nxt;
  logic              target_r, target_nxt;
  logic              dir_r, dir_nxt;
  logic              run_r, run_nxt;
  logic              rpt_valid;
  report_t           rpt_code;
  logic              hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TimeoutReset;
    end else if (cfg_wr_en) begin
      timeout_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      wait_r    <= '0;
      pending_r <= 1'b0;
      target_r  <= 1'b0;
      dir_r     <= 1'b0;
      run_r     <= 1'b0;
    end else if (tick_en) begin
      phase_r   <= phase_nxt;
      wait_r    <= wait_nxt;
      pending_r <= pending_nxt;
      target_r  <= target_nxt;
      dir_r     <= dir_nxt;
      run_r     <= run_nxt;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    wait_nxt    = wait_r;
    pending_nxt = pending_r;
    target_nxt  = target_r;
    dir_nxt     = dir_r;
    run_nxt     = run_r;
    rpt_valid   = 1'b0;
    rpt_code    = RPT_DONE;
    hit         = target_r ? tick_in.endpoint_on_hit : tick_in.endpoint_off_hit;

    unique case (phase_r)
      PH_START: begin
        if (tick_in.driver_released) begin
          run_nxt   = 1'b1;
          phase_nxt = PH_WAIT;
        end else begin
          phase_nxt = tick_in.driver_ok ? PH_BLOCKED : PH_FAULT;
        end
      end
      PH_WAIT: begin
        if (tick_in.driver_released) begin
          if (wait_r >= timeout_r) begin
            phase_nxt = PH_TIMEOUT;
          end else if (hit) begin
            phase_nxt = PH_DONE;
          end
          if (wait_r != WaitMax) begin
            wait_nxt = wait_r + TickW'(1);
          end
        end else begin
          phase_nxt = tick_in.driver_ok ? PH_BLOCKED : PH_FAULT;
        end
      end
      PH_DONE, PH_TIMEOUT, PH_FAULT, PH_BLOCKED: begin
        run_nxt     = 1'b0;
        pending_nxt = 1'b0;
        rpt_valid   = 1'b1;
        phase_nxt   = PH_IDLE;
        case (phase_r)
          PH_DONE: begin
            rpt_code = RPT_DONE;
            dir_nxt  = ~target_r;
          end
          PH_TIMEOUT: rpt_code = RPT_TIMEOUT;
          PH_FAULT:   rpt_code = RPT_FAULT;
          default:    rpt_code = RPT_BLOCKED;
        endcase
      end
      default: begin
        if (!pending_r && tick_in.move_request) begin
          pending_nxt = 1'b1;
          target_nxt  = tick_in.move_target;
        end
        if (pending_nxt) begin
          if (tick_in.driver_released) begin
            dir_nxt   = target_nxt;
            phase_nxt = PH_START;
            wait_nxt  = '0;
          end else begin
            phase_nxt = tick_in.driver_ok ? PH_BLOCKED : PH_FAULT;
          end
        end
      end
    endcase

    tick_out.motor_direction = dir_nxt;
    tick_out.motor_run       = run_nxt;
    tick_out.report_valid    = rpt_valid;
    tick_out.report_code     = rpt_code;
    tick_out.busy_res        = pending_nxt;
  end

endmodule

// ===== rtl/wmms_out_reg.sv =====
// ----------------------------------------------------------------------------
// wmms_out_reg
// Result register of the output stream; takes a new beat while the old one
// is being taken.
// ----------------------------------------------------------------------------
module wmms_out_reg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load,
  input  wmms_pkg::tick_out_t            load_data,
  output logic                           can_load,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [wmms_pkg::OutDataW-1:0]  out_tdata
);
  import wmms_pkg::*;

  logic      valid_r;
  tick_out_t data_r;

  assign can_load = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {2'b00, data_r.busy_res, data_r.report_code,
                       data_r.report_valid, data_r.motor_run, data_r.motor_direction};

endmodule

// ===== rtl/wall_motor_move_sequencer.sv =====
// ----------------------------------------------------------------------------
// wall_motor_move_sequencer
// Steps a wall motor move through direction, start and end-switch wait.
// ----------------------------------------------------------------------------
// Each input beat is one 10 ms tick carrying a move request, its target,
// the driver flags and both end-switch levels. Each input beat produces
// exactly one output beat with the direction and start line levels, a
// finish report and the busy flag.
// The sequencer state is updated in the cycle the input beat is accepted
// and the result is held in one output register, so an output beat appears
// in the cycle after its input beat. One beat is accepted every cycle; the
// only limit is the single output register, which accepts a new beat in
// the same cycle its current beat is taken.
// When the receiver stalls, in_tready drops once the output register is
// full and the state stays frozen until the beat is taken.
// Users must write the timeout register via cfg_wr_en and cfg_wr_data
// only while no tick is in flight; this is not enforced. Synchronous reset
// sets idle, motor lines low, no move pending and a timeout of 500 ticks.
// ----------------------------------------------------------------------------
module wall_motor_move_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [wmms_pkg::TickW-1:0]     cfg_wr_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // move_request, move_target, driver_released, driver_ok,
  // endpoint_on_hit, endpoint_off_hit, two zero bits
  input  logic [wmms_pkg::InDataW-1:0]   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // motor_direction, motor_run, report_valid, report_code[1:0],
  // busy_res, two zero bits
  output logic [wmms_pkg::OutDataW-1:0]  out_tdata
);
  import wmms_pkg::*;

  tick_in_t  tick_in;
  tick_out_t tick_out;
  logic      in_fire;

  assign tick_in.move_request     = in_tdata[0];
  assign tick_in.move_target      = in_tdata[1];
  assign tick_in.driver_released  = in_tdata[2];
  assign tick_in.driver_ok        = in_tdata[3];
  assign tick_in.endpoint_on_hit  = in_tdata[4];
  assign tick_in.endpoint_off_hit = in_tdata[5];

  assign in_fire = in_tvalid && in_tready;

  wmms_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tick_en     (in_fire),
    .tick_in     (tick_in),
    .tick_out    (tick_out)
  );

  wmms_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .load_data  (tick_out),
    .can_load   (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_report_stops_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1] && !out_tdata[5])
    else $error("finish report with motor running or move still pending");

  a_run_implies_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> out_tdata[5])
    else $error("motor running without a pending move");

  a_code_only_with_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[4:3] == 2'b00)
    else $error("report code set without a report");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input accepted while the result register is stalled");

endmodule
